@@ rtl/core/boundary_fill_four_connected_defines.svh @@
// Assertion macros for the boundary fill block.
// Needs a clock named clock and a synchronous reset named reset in the including module.
`ifndef BOUNDARY_FILL_FOUR_CONNECTED_DEFINES_SVH
`define BOUNDARY_FILL_FOUR_CONNECTED_DEFINES_SVH

// Condition that must hold at every edge outside reset.
`define BFILL4_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication.
`define BFILL4_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/bfill4_pkg.sv @@
// Shared types and codes for the four-connected boundary fill block.
// No dependencies; used by boundary_fill_four_connected.
`timescale 1ns / 1ps
`default_nettype none

package bfill4_pkg;

   localparam int COLOR_W     = 24;
   localparam int COUNT_W     = 13;
   localparam int COORD_W     = 6;
   localparam int OP_W        = 2;
   localparam int CSR_INDEX_W = 1;

   localparam logic [COLOR_W-1:0] FILL_COLOR_RESET     = 24'hFF0000;
   localparam logic [COLOR_W-1:0] BOUNDARY_COLOR_RESET = 24'hFFFFFF;

   localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [OP_W-1:0] OP_READ   = 2'd1;
   localparam logic [OP_W-1:0] OP_FILL   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FILL_COLOR     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUNDARY_COLOR = 1'd1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_WAIT,
      ST_SEED_CHECK,
      ST_FILL_POP,
      ST_FILL_LOAD,
      ST_FILL_CHECK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      DIR_RIGHT,
      DIR_LEFT,
      DIR_UP,
      DIR_DOWN
   } dir_type;

endpackage

`default_nettype wire

@@ rtl/core/boundary_fill_four_connected.sv @@
// Frame store with pixel write/read and a stack-driven four-connected boundary fill.
// Depends on bfill4_pkg and boundary_fill_four_connected_defines.svh.
//
//   channel | direction | signals
//   req     | in        | req_valid/req_ready, operation, pos_x, pos_y, pixel_value
//   rsp     | out       | rsp_valid/rsp_ready, read_color, painted_count
//   csr     | in        | csr_valid/csr_ready (always ready), csr_index, csr_data
//
// After reset a clearing pass zeroes all FRAME_WIDTH*FRAME_HEIGHT words of the frame store,
// with req_ready low; csr writes are taken throughout.
// Write passes through ST_IDLE and ST_DONE; read adds ST_READ_WAIT. Fill checks the seed,
// then pops and loads each stacked pixel and probes its four neighbours, one neighbour probe per cycle.
// One item at a time; a finished result sits in the output register, and the next item
// is accepted meanwhile, its own result then holding until the register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "boundary_fill_four_connected_defines.svh"

module boundary_fill_four_connected #(
   parameter int FRAME_WIDTH  = 64,
   parameter int FRAME_HEIGHT = 64
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  wire  [bfill4_pkg::OP_W-1:0]            req_operation,
   input  wire  [bfill4_pkg::COORD_W-1:0]         req_pos_x,
   input  wire  [bfill4_pkg::COORD_W-1:0]         req_pos_y,
   input  wire  [bfill4_pkg::COLOR_W-1:0]         req_pixel_value,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic [bfill4_pkg::COLOR_W-1:0]         rsp_read_color,
   output logic [bfill4_pkg::COUNT_W-1:0]         rsp_painted_count,
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire  [bfill4_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [bfill4_pkg::COLOR_W-1:0]         csr_data
);

   localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int AW     = $clog2(PIXELS);
   localparam int SW     = $clog2(PIXELS + 1);
   localparam int XW     = $clog2(FRAME_WIDTH);
   localparam int YW     = $clog2(FRAME_HEIGHT);
   localparam int EW     = XW + YW;
   localparam int CW     = bfill4_pkg::COLOR_W;
   localparam int NW     = bfill4_pkg::COUNT_W;

   typedef struct packed {
      logic          ok;
      logic [YW-1:0] y;
      logic [XW-1:0] x;
   } nbr_type;

   function automatic logic [AW-1:0] pixel_addr(input logic [XW-1:0] x,
                                                input logic [YW-1:0] y);
      logic [31:0] lin;
      lin = 32'(y) * 32'(FRAME_WIDTH) + 32'(x);
      return lin[AW-1:0];
   endfunction

   function automatic nbr_type neighbour(input logic [XW-1:0] x,
                                         input logic [YW-1:0] y,
                                         input bfill4_pkg::dir_type d);
      nbr_type n;
      n = '0;
      case (d)
         bfill4_pkg::DIR_RIGHT: begin
            n.ok = (x != XW'(FRAME_WIDTH - 1));
            n.x  = x + XW'(1);
            n.y  = y;
         end
         bfill4_pkg::DIR_LEFT: begin
            n.ok = (x != '0);
            n.x  = x - XW'(1);
            n.y  = y;
         end
         bfill4_pkg::DIR_UP: begin
            n.ok = (y != YW'(FRAME_HEIGHT - 1));
            n.x  = x;
            n.y  = y + YW'(1);
         end
         bfill4_pkg::DIR_DOWN: begin
            n.ok = (y != '0);
            n.x  = x;
            n.y  = y - YW'(1);
         end
         default: n = '0;
      endcase
      return n;
   endfunction

   // ---------------- registers ----------------
   bfill4_pkg::state_type state_ff, state_in;
   bfill4_pkg::dir_type   dir_ff, dir_in;
   logic [XW-1:0]         cur_x_ff, cur_x_in;
   logic [YW-1:0]         cur_y_ff, cur_y_in;
   logic                  seed_ok_ff, seed_ok_in;
   logic [SW-1:0]         stack_top_ff, stack_top_in;
   logic [NW-1:0]         count_ff, count_in;
   logic [CW-1:0]         res_color_ff, res_color_in;
   logic [AW-1:0]         clear_addr_ff, clear_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]         rsp_color_ff, rsp_color_in;
   logic [NW-1:0]         rsp_count_ff, rsp_count_in;
   logic [CW-1:0]         fill_color_ff, boundary_color_ff;

   // ---------------- memories ----------------
   logic [CW-1:0] frame_store_mem [PIXELS];
   logic [EW-1:0] pending_stack_mem [PIXELS];
   logic [CW-1:0] frame_rd_ff;
   logic [EW-1:0] stack_rd_ff;

   logic          frame_rd_en, frame_wr_en;
   logic [AW-1:0] frame_rd_addr, frame_wr_addr;
   logic [CW-1:0] frame_wr_data;
   logic          stack_push, stack_pop;
   logic [EW-1:0] stack_wr_data;
   logic [SW-1:0] stack_top_dec;

   // ---------------- combinational helpers ----------------
   logic [31:0]   pos_x_wide, pos_y_wide;
   logic          req_inside;
   logic [XW-1:0] seed_x;
   logic [YW-1:0] seed_y;
   logic          may_paint;
   logic          out_free;
   nbr_type       cand, cand_next, first_nbr;
   bfill4_pkg::dir_type dir_next;

   assign pos_x_wide = 32'(req_pos_x);
   assign pos_y_wide = 32'(req_pos_y);
   assign req_inside = (pos_x_wide < 32'(FRAME_WIDTH)) && (pos_y_wide < 32'(FRAME_HEIGHT));
   assign seed_x     = pos_x_wide[XW-1:0];
   assign seed_y     = pos_y_wide[YW-1:0];
   assign may_paint  = (frame_rd_ff != boundary_color_ff) && (frame_rd_ff != fill_color_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign stack_top_dec = stack_top_ff - SW'(1);

   always_comb begin
      case (dir_ff)
         bfill4_pkg::DIR_RIGHT: dir_next = bfill4_pkg::DIR_LEFT;
         bfill4_pkg::DIR_LEFT:  dir_next = bfill4_pkg::DIR_UP;
         bfill4_pkg::DIR_UP:    dir_next = bfill4_pkg::DIR_DOWN;
         default:               dir_next = bfill4_pkg::DIR_RIGHT;
      endcase
   end

   assign cand      = neighbour(cur_x_ff, cur_y_ff, dir_ff);
   assign cand_next = neighbour(cur_x_ff, cur_y_ff, dir_next);
   assign first_nbr = neighbour(stack_rd_ff[XW-1:0], stack_rd_ff[EW-1:XW],
                                bfill4_pkg::DIR_RIGHT);

   assign req_ready         = (state_ff == bfill4_pkg::ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_color    = rsp_color_ff;
   assign rsp_painted_count = rsp_count_ff;

   // ---------------- next state ----------------
   always_comb begin
      state_in      = state_ff;
      dir_in        = dir_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      seed_ok_in    = seed_ok_ff;
      stack_top_in  = stack_top_ff;
      count_in      = count_ff;
      res_color_in  = res_color_ff;
      clear_addr_in = clear_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_color_in  = rsp_color_ff;
      rsp_count_in  = rsp_count_ff;
      frame_rd_en   = 1'b0;
      frame_rd_addr = '0;
      frame_wr_en   = 1'b0;
      frame_wr_addr = '0;
      frame_wr_data = '0;
      stack_push    = 1'b0;
      stack_pop     = 1'b0;
      stack_wr_data = '0;

      case (state_ff)
         bfill4_pkg::ST_CLEAR: begin
            frame_wr_en   = 1'b1;
            frame_wr_addr = clear_addr_ff;
            clear_addr_in = clear_addr_ff + AW'(1);
            if (clear_addr_ff == AW'(PIXELS - 1)) begin
               state_in = bfill4_pkg::ST_IDLE;
            end
         end
         bfill4_pkg::ST_IDLE: begin
            if (req_valid) begin
               res_color_in = '0;
               count_in     = '0;
               state_in     = bfill4_pkg::ST_DONE;
               case (req_operation)
                  bfill4_pkg::OP_WRITE: begin
                     frame_wr_en   = req_inside;
                     frame_wr_addr = pixel_addr(seed_x, seed_y);
                     frame_wr_data = req_pixel_value;
                  end
                  bfill4_pkg::OP_READ: begin
                     if (req_inside) begin
                        frame_rd_en   = 1'b1;
                        frame_rd_addr = pixel_addr(seed_x, seed_y);
                        state_in      = bfill4_pkg::ST_READ_WAIT;
                     end
                  end
                  bfill4_pkg::OP_FILL: begin
                     frame_rd_en   = req_inside;
                     frame_rd_addr = pixel_addr(seed_x, seed_y);
                     cur_x_in      = seed_x;
                     cur_y_in      = seed_y;
                     seed_ok_in    = req_inside;
                     state_in      = bfill4_pkg::ST_SEED_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         bfill4_pkg::ST_READ_WAIT: begin
            res_color_in = frame_rd_ff;
            state_in     = bfill4_pkg::ST_DONE;
         end
         bfill4_pkg::ST_SEED_CHECK: begin
            if (seed_ok_ff && may_paint) begin
               frame_wr_en   = 1'b1;
               frame_wr_addr = pixel_addr(cur_x_ff, cur_y_ff);
               frame_wr_data = fill_color_ff;
               stack_push    = 1'b1;
               stack_wr_data = {cur_y_ff, cur_x_ff};
               stack_top_in  = stack_top_ff + SW'(1);
               count_in      = count_ff + NW'(1);
            end
            state_in = bfill4_pkg::ST_FILL_POP;
         end
         bfill4_pkg::ST_FILL_POP: begin
            if (stack_top_ff == '0) begin
               state_in = bfill4_pkg::ST_DONE;
            end else begin
               stack_pop    = 1'b1;
               stack_top_in = stack_top_dec;
               state_in     = bfill4_pkg::ST_FILL_LOAD;
            end
         end
         bfill4_pkg::ST_FILL_LOAD: begin
            cur_x_in      = stack_rd_ff[XW-1:0];
            cur_y_in      = stack_rd_ff[EW-1:XW];
            dir_in        = bfill4_pkg::DIR_RIGHT;
            frame_rd_en   = first_nbr.ok;
            frame_rd_addr = pixel_addr(first_nbr.x, first_nbr.y);
            state_in      = bfill4_pkg::ST_FILL_CHECK;
         end
         bfill4_pkg::ST_FILL_CHECK: begin
            // neighbours of one centre are distinct, so the probe of the next one
            // never hits the pixel written this cycle
            if (cand.ok && may_paint) begin
               frame_wr_en   = 1'b1;
               frame_wr_addr = pixel_addr(cand.x, cand.y);
               frame_wr_data = fill_color_ff;
               stack_push    = 1'b1;
               stack_wr_data = {cand.y, cand.x};
               stack_top_in  = stack_top_ff + SW'(1);
               count_in      = count_ff + NW'(1);
            end
            if (dir_ff == bfill4_pkg::DIR_DOWN) begin
               state_in = bfill4_pkg::ST_FILL_POP;
            end else begin
               dir_in        = dir_next;
               frame_rd_en   = cand_next.ok;
               frame_rd_addr = pixel_addr(cand_next.x, cand_next.y);
            end
         end
         bfill4_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = res_color_ff;
               rsp_count_in = count_ff;
               state_in     = bfill4_pkg::ST_IDLE;
            end
         end
         default: state_in = bfill4_pkg::ST_IDLE;
      endcase
   end

   // ---------------- state registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfill4_pkg::ST_CLEAR;
         clear_addr_ff <= '0;
         stack_top_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         stack_top_ff  <= stack_top_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff       <= dir_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      seed_ok_ff   <= seed_ok_in;
      count_ff     <= count_in;
      res_color_ff <= res_color_in;
      rsp_color_ff <= rsp_color_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_color_ff     <= bfill4_pkg::FILL_COLOR_RESET;
         boundary_color_ff <= bfill4_pkg::BOUNDARY_COLOR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bfill4_pkg::CSR_FILL_COLOR:     fill_color_ff     <= csr_data;
            bfill4_pkg::CSR_BOUNDARY_COLOR: boundary_color_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (frame_wr_en) begin
         frame_store_mem[frame_wr_addr] <= frame_wr_data;
      end
      if (frame_rd_en) begin
         frame_rd_ff <= frame_store_mem[frame_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (stack_push) begin
         pending_stack_mem[stack_top_ff[AW-1:0]] <= stack_wr_data;
      end
      if (stack_pop) begin
         stack_rd_ff <= pending_stack_mem[stack_top_dec[AW-1:0]];
      end
   end

   // ---------------- assertions ----------------
   `BFILL4_ASSERT_ALWAYS(a_stack_bound, stack_top_ff <= SW'(PIXELS), "stack overran the frame")
   `BFILL4_ASSERT_IMPLY(a_stack_empty_idle, req_ready, stack_top_ff == '0, "stack not empty between items")
   `BFILL4_ASSERT_ALWAYS(a_stack_one_port, !(stack_push && stack_pop), "stack push and pop together")
   `BFILL4_ASSERT_IMPLY(a_fill_paints_fill, (state_ff == bfill4_pkg::ST_FILL_CHECK) && frame_wr_en, frame_wr_data == fill_color_ff, "fill wrote a colour other than the fill colour")
   `BFILL4_ASSERT_IMPLY(a_rsp_exclusive, rsp_valid_ff && (rsp_count_ff != '0), rsp_color_ff == '0, "result carries both a colour and a count")

endmodule

`default_nettype wire
